// File: hw/rtl/sfd_pkg.sv
// Shared types, constants and helpers for the serial-bus frame decoder.
`timescale 1ns / 1ps

package sfd_pkg;

  localparam int unsigned FRAME_BYTES = 24;
  localparam int unsigned FILL_W      = $clog2(FRAME_BYTES + 1);
  localparam int unsigned CHAN_W      = 12;
  localparam int unsigned CNT_W       = 16;

  localparam logic [7:0]        SYNC_BYTE   = 8'h0F;
  localparam logic [CHAN_W-1:0] CHAN_OFFSET = 12'd1980;
  localparam int unsigned       FLAG_BYTE   = 23;
  localparam int unsigned       LOST_BIT    = 2;
  localparam int unsigned       FAILSAFE_BIT = 3;

  typedef logic [7:0]        byte_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [FILL_W-1:0] fill_t;

  typedef enum logic [0:0] {
    CFG_GAP_TICKS  = 1'b0,
    CFG_CHECK_MODE = 1'b1
  } cfg_reg_e;

  // 11-bit channel field to output value
  function automatic chan_t chan_f(input logic [10:0] raw);
    chan_f = {1'b0, raw} + CHAN_OFFSET;
  endfunction

endpackage

// File: hw/rtl/sfd_cell.sv
// One byte cell of the frame shift chain.
`timescale 1ns / 1ps

module sfd_cell
  import sfd_pkg::*;
(
  input  logic  clk_i,
  input  logic  shift_i,
  input  byte_t byte_i,
  output byte_t byte_o
);

  byte_t byte_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

endmodule

// File: hw/rtl/sbus_frame_receiver_decoder.sv
// Top level: frame sync, byte cell chain, channel unpack and result register.
// A completing byte's result is registered and shows on the output in the cycle after its beat.
// Throughput: one input beat per cycle; a pending result stalls input only
// while out_ready_i is low (single output register, ready passes through).
// Reset (rst_ni low, async): fill count, counters, timing and config clear; byte cells
// (byte k ends in cell 23-k) hold no reset value and are only read once a frame has filled.
`timescale 1ns / 1ps

module sbus_frame_receiver_decoder
  import sfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // input beats
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        framing_error_i,
  input  logic        parity_error_i,
  input  logic [15:0] heartbeat_count_i,
  // result beats
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] chan1_o,
  output logic [11:0] chan2_o,
  output logic [11:0] chan3_o,
  output logic [11:0] chan4_o,
  output logic [11:0] chan5_o,
  output logic [11:0] chan6_o,
  output logic [11:0] chan7_o,
  output logic [15:0] lost_total_o,
  output logic [15:0] failsafe_total_o,
  output logic [15:0] frame_interval_o,
  output logic [15:0] framing_total_o,
  output logic [15:0] parity_total_o
);

  // configuration
  cnt_t gap_q;
  logic check_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q   <= '0;
      check_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_GAP_TICKS:  gap_q   <= cfg_wdata_i;
        CFG_CHECK_MODE: check_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // handshake
  logic out_valid_q;
  logic in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // frame control state
  fill_t fill_q, fill_d;
  cnt_t  start_q, start_d;
  cnt_t  ival_q, ival_d;
  logic  rep_q, rep_d;
  cnt_t  lost_q, lost_d;
  cnt_t  fsafe_q, fsafe_d;
  cnt_t  ferr_q, ferr_d;
  cnt_t  perr_q, perr_d;

  logic  bad_byte;
  logic  restart;
  cnt_t  dt;
  fill_t fill_eff;
  logic  rep_eff;
  logic  store_en;
  logic  emit;

  byte_t byte_q [FRAME_BYTES];
  byte_t frame_byte [FRAME_BYTES];

  // byte b of the frame sits in cell FRAME_BYTES-1-b
  for (genvar b = 0; b < FRAME_BYTES; b++) begin : g_frame_byte
    assign frame_byte[b] = byte_q[FRAME_BYTES-1-b];
  end

  always_comb begin
    fill_d   = fill_q;
    start_d  = start_q;
    ival_d   = ival_q;
    rep_d    = rep_q;
    lost_d   = lost_q;
    fsafe_d  = fsafe_q;
    ferr_d   = ferr_q;
    perr_d   = perr_q;
    store_en = 1'b0;
    emit     = 1'b0;

    bad_byte = check_q && (framing_error_i || parity_error_i);
    dt       = heartbeat_count_i - start_q;
    restart  = !bad_byte && (dt >= gap_q) && (rx_byte_i == SYNC_BYTE);
    fill_eff = restart ? '0 : fill_q;
    rep_eff  = restart ? 1'b0 : rep_q;

    if (in_fire) begin
      if (bad_byte) begin
        // framing error wins over parity error
        if (framing_error_i) begin
          ferr_d = ferr_q + 1'b1;
        end else begin
          perr_d = perr_q + 1'b1;
        end
      end else begin
        if (restart) begin
          start_d = heartbeat_count_i;
          ival_d  = dt;
        end
        rep_d = rep_eff;
        if (fill_eff < fill_t'(FRAME_BYTES)) begin
          store_en = 1'b1;
          fill_d   = fill_eff + 1'b1;
        end else if (!(check_q && rx_byte_i != 8'h00) && !rep_eff) begin
          emit  = 1'b1;
          rep_d = 1'b1;
          if (frame_byte[FLAG_BYTE][LOST_BIT]) begin
            lost_d = lost_q + 1'b1;
          end
          if (frame_byte[FLAG_BYTE][FAILSAFE_BIT]) begin
            fsafe_d = fsafe_q + 1'b1;
          end
        end else begin
          fill_d = fill_eff;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      start_q <= '0;
      ival_q  <= '0;
      rep_q   <= 1'b0;
      lost_q  <= '0;
      fsafe_q <= '0;
      ferr_q  <= '0;
      perr_q  <= '0;
    end else begin
      fill_q  <= fill_d;
      start_q <= start_d;
      ival_q  <= ival_d;
      rep_q   <= rep_d;
      lost_q  <= lost_d;
      fsafe_q <= fsafe_d;
      ferr_q  <= ferr_d;
      perr_q  <= perr_d;
    end
  end

  // byte cell chain
  for (genvar k = 0; k < FRAME_BYTES; k++) begin : g_cell
    if (k == 0) begin : g_head
      sfd_cell u_cell (
        .clk_i  (clk_i),
        .shift_i(store_en),
        .byte_i (rx_byte_i),
        .byte_o (byte_q[k])
      );
    end else begin : g_body
      sfd_cell u_cell (
        .clk_i  (clk_i),
        .shift_i(store_en),
        .byte_i (byte_q[k-1]),
        .byte_o (byte_q[k])
      );
    end
  end

  // result register
  chan_t ch1_q, ch2_q, ch3_q, ch4_q, ch5_q, ch6_q, ch7_q;
  cnt_t  lost_o_q, fsafe_o_q, ival_o_q, ferr_o_q, perr_o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      ch1_q     <= chan_f({frame_byte[2][2:0], frame_byte[1]});
      ch2_q     <= chan_f({frame_byte[3][5:0], frame_byte[2][7:3]});
      ch3_q     <= chan_f({frame_byte[5][0], frame_byte[4], frame_byte[3][7:6]});
      ch4_q     <= chan_f({frame_byte[6][3:0], frame_byte[5][7:1]});
      ch5_q     <= chan_f({frame_byte[7][6:0], frame_byte[6][7:4]});
      ch6_q     <= chan_f({frame_byte[9][1:0], frame_byte[8], frame_byte[7][7]});
      ch7_q     <= chan_f({frame_byte[10][4:0], frame_byte[9][7:2]});
      lost_o_q  <= lost_d;
      fsafe_o_q <= fsafe_d;
      ival_o_q  <= ival_q;
      ferr_o_q  <= ferr_q;
      perr_o_q  <= perr_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign chan1_o          = ch1_q;
  assign chan2_o          = ch2_q;
  assign chan3_o          = ch3_q;
  assign chan4_o          = ch4_q;
  assign chan5_o          = ch5_q;
  assign chan6_o          = ch6_q;
  assign chan7_o          = ch7_q;
  assign lost_total_o     = lost_o_q;
  assign failsafe_total_o = fsafe_o_q;
  assign frame_interval_o = ival_o_q;
  assign framing_total_o  = ferr_o_q;
  assign parity_total_o   = perr_o_q;

`ifndef ASSERT_OFF
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= fill_t'(FRAME_BYTES))
    else $error("fill count above frame length");

  a_rep_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_q |-> fill_q == fill_t'(FRAME_BYTES))
    else $error("frame marked reported before it filled");

  a_emit_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> fill_q == fill_t'(FRAME_BYTES) && !restart)
    else $error("result from a frame that is not full");

  a_emit_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> rep_q && out_valid_q)
    else $error("reported flag or result beat missing after completion");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_q && !out_ready_i)
    else $error("input stalled without a pending result");
`endif

endmodule

// File: tb/sbus_frame_receiver_decoder_tb.sv
// Self-checking testbench for the serial-bus frame decoder: drives byte beats, predicts frames.
`timescale 1ns / 1ps

module sbus_frame_receiver_decoder_tb;
  import sfd_pkg::*;

  localparam int unsigned RUN_BEATS   = 1350;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned NUM_PHASES  = 6;

  typedef struct packed {
    chan_t [6:0] chan;  // chan[0] is channel 1
    cnt_t        lost;
    cnt_t        failsafe;
    cnt_t        interval;
    cnt_t        framing;
    cnt_t        parity;
  } frame_result_t;

  class frame_checker;
    byte_t         store [FRAME_BYTES];
    int unsigned   fill;
    bit            reported;
    cnt_t          start_tick, interval, lost, failsafe, framing, parity;
    cnt_t          gap_ticks;
    bit            check_mode;
    frame_result_t frames_due[$];
    int unsigned   mismatches, frames_seen, dropped_beats;

    function new();
      fill       = 0;
      reported   = 1'b0;
      start_tick = '0;
      interval   = '0;
      lost       = '0;
      failsafe   = '0;
      framing    = '0;
      parity     = '0;
      gap_ticks  = '0;
      check_mode = 1'b0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [15:0] val);
      case (idx)
        CFG_GAP_TICKS:  gap_ticks  = val;
        CFG_CHECK_MODE: check_mode = val[0];
        default: ;
      endcase
    endfunction

    // Advance the decoder state by one accepted beat; queue a frame if it completes one.
    function void take_byte(byte_t b, bit ferr, bit perr, cnt_t hb);
      cnt_t          dt;
      logic [79:0]   bits;
      frame_result_t r;
      int            k;
      if (check_mode && (ferr || perr)) begin
        // framing error wins when both flags are set
        if (ferr) framing++;
        else parity++;
        dropped_beats++;
        return;
      end
      dt = hb - start_tick;
      if (dt >= gap_ticks && b == SYNC_BYTE) begin
        fill       = 0;
        start_tick = hb;
        interval   = dt;
        reported   = 1'b0;
      end
      if (fill < FRAME_BYTES) begin
        store[fill] = b;
        fill++;
        return;
      end
      if (check_mode && b != 8'h00) return;
      if (reported) return;
      reported = 1'b1;
      if (store[FLAG_BYTE][LOST_BIT]) lost++;
      if (store[FLAG_BYTE][FAILSAFE_BIT]) failsafe++;
      // channel bits are packed LSB first starting at byte 1
      for (k = 0; k < 10; k++) bits[k*8 +: 8] = store[k+1];
      for (k = 0; k < 7; k++) r.chan[k] = {1'b0, bits[k*11 +: 11]} + CHAN_OFFSET;
      r.lost     = lost;
      r.failsafe = failsafe;
      r.interval = interval;
      r.framing  = framing;
      r.parity   = parity;
      frames_due.push_back(r);
    endfunction

    function void note_miss(string what, logic [15:0] want, logic [15:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in frame %0d, %s: expected %0d, got %0d",
                 frames_seen, what, want, got);
    endfunction

    function void check_frame(frame_result_t got);
      frame_result_t want;
      int            k;
      frames_seen++;
      if (frames_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected frame %0d: chan1 %0d, lost %0d, interval %0d",
                   frames_seen, got.chan[0], got.lost, got.interval);
        return;
      end
      want = frames_due.pop_front();
      for (k = 0; k < 7; k++)
        if (got.chan[k] !== want.chan[k])
          note_miss($sformatf("chan%0d", k + 1), want.chan[k], got.chan[k]);
      if (got.lost !== want.lost) note_miss("lost_total", want.lost, got.lost);
      if (got.failsafe !== want.failsafe)
        note_miss("failsafe_total", want.failsafe, got.failsafe);
      if (got.interval !== want.interval)
        note_miss("frame_interval", want.interval, got.interval);
      if (got.framing !== want.framing)
        note_miss("framing_total", want.framing, got.framing);
      if (got.parity !== want.parity) note_miss("parity_total", want.parity, got.parity);
    endfunction
  endclass

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        cfg_we_i          = 1'b0;
  logic [0:0]  cfg_idx_i         = CFG_GAP_TICKS;
  logic [15:0] cfg_wdata_i       = '0;
  logic        in_valid_i        = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i         = '0;
  logic        framing_error_i   = 1'b0;
  logic        parity_error_i    = 1'b0;
  logic [15:0] heartbeat_count_i = '0;
  logic        out_valid_o;
  logic        out_ready_i       = 1'b1;
  logic [11:0] chan1_o, chan2_o, chan3_o, chan4_o, chan5_o, chan6_o, chan7_o;
  logic [15:0] lost_total_o, failsafe_total_o, frame_interval_o;
  logic [15:0] framing_total_o, parity_total_o;

  frame_checker sb;
  cnt_t         hb_now     = '0;
  bit           send_idle  = 1'b0;
  bit           recv_idle  = 1'b0;
  int unsigned  stall_left = 0;
  int unsigned  beats_in   = 0;
  int unsigned  cycles     = 0;

  sbus_frame_receiver_decoder u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .framing_error_i  (framing_error_i),
    .parity_error_i   (parity_error_i),
    .heartbeat_count_i(heartbeat_count_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .chan1_o          (chan1_o),
    .chan2_o          (chan2_o),
    .chan3_o          (chan3_o),
    .chan4_o          (chan4_o),
    .chan5_o          (chan5_o),
    .chan6_o          (chan6_o),
    .chan7_o          (chan7_o),
    .lost_total_o     (lost_total_o),
    .failsafe_total_o (failsafe_total_o),
    .frame_interval_o (frame_interval_o),
    .framing_total_o  (framing_total_o),
    .parity_total_o   (parity_total_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d frames still due", cycles, sb.frames_due.size());
      $display("tb: failure");
      $finish;
    end
  end

  // result side back-pressure: random stalls of out_ready_i, started only while recv_idle is set
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (recv_idle && $urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(0, 2);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    frame_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.chan[0]  = chan1_o;
      got.chan[1]  = chan2_o;
      got.chan[2]  = chan3_o;
      got.chan[3]  = chan4_o;
      got.chan[4]  = chan5_o;
      got.chan[5]  = chan6_o;
      got.chan[6]  = chan7_o;
      got.lost     = lost_total_o;
      got.failsafe = failsafe_total_o;
      got.interval = frame_interval_o;
      got.framing  = framing_total_o;
      got.parity   = parity_total_o;
      sb.check_frame(got);
    end
  end

  function automatic bit err_flag();
    return $urandom_range(0, 29) == 0;
  endfunction

  task automatic send_beat(byte_t b, bit ferr, bit perr, cnt_t hb);
    if (send_idle && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    rx_byte_i         <= b;
    framing_error_i   <= ferr;
    parity_error_i    <= perr;
    heartbeat_count_i <= hb;
    do @(posedge clk_i); while (!in_ready_o);
    if (!(sb.check_mode && (ferr || perr))) beats_in++;
    sb.take_byte(b, ferr, perr, hb);
  endtask

  task automatic set_regs(cnt_t gap, bit chk);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_GAP_TICKS;
    cfg_wdata_i <= gap;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_CHECK_MODE;
    cfg_wdata_i <= {15'b0, chk};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.write_reg(CFG_GAP_TICKS, gap);
    sb.write_reg(CFG_CHECK_MODE, {15'b0, chk});
  endtask

  // hold the sender until every frame is back, then let the pipe settle
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.frames_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_frame();
    int unsigned room;
    int unsigned i;
    // sync normally lands at or just past the gap; now and then anywhere
    room = 16'hFFFF - sb.gap_ticks;
    if ($urandom_range(0, 9) == 0)
      hb_now = cnt_t'(sb.start_tick + $urandom_range(0, 65535));
    else
      hb_now = cnt_t'(sb.start_tick + sb.gap_ticks +
                      $urandom_range(0, (room > 8) ? 8 : room));
    send_beat(SYNC_BYTE, err_flag(), err_flag(), hb_now);
    for (i = 1; i < FRAME_BYTES; i++) begin
      hb_now = hb_now + cnt_t'($urandom_range(0, 3));
      send_beat(byte_t'($urandom_range(0, 255)), err_flag(), err_flag(), hb_now);
    end
    hb_now++;
    // a non-zero end beat leaves the frame waiting in check mode, unless it is a sync byte that restarts the frame
    if (sb.check_mode && $urandom_range(0, 4) == 0)
      send_beat(byte_t'($urandom_range(1, 255)), err_flag(), err_flag(), hb_now);
    send_beat(sb.check_mode ? 8'h00 : byte_t'($urandom_range(0, 255)),
              err_flag(), err_flag(), hb_now);
    // trailing beats after completion must not report again
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) begin
        hb_now++;
        send_beat($urandom_range(0, 1) ? 8'h00 : byte_t'($urandom_range(0, 255)),
                  err_flag(), err_flag(), hb_now);
      end
  endtask

  initial begin
    int unsigned p, i, target;
    cnt_t        gap;
    bit          chk;
    bit          phase_idle;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full-scale channels across a heartbeat wrap, then repeat completion with flags set
    set_regs(16'd0, 1'b0);
    send_beat(SYNC_BYTE, 1'b0, 1'b0, 16'hFFF0);
    for (i = 1; i < FRAME_BYTES; i++)
      send_beat((i <= 10) ? 8'hFF : ((i == FLAG_BYTE) ? 8'h0C : 8'h00), 1'b0, 1'b0,
                cnt_t'(16'hFFF0 + i));
    send_beat(8'hFF, 1'b0, 1'b0, 16'hFFFE);
    send_beat(8'h00, 1'b1, 1'b1, 16'hFFFF);
    drain();

    // check mode: framing only, parity only, both; then a zero beat on a reported frame
    set_regs(16'd0, 1'b1);
    send_beat(8'h0F, 1'b1, 1'b0, 16'h0000);
    send_beat(8'h55, 1'b0, 1'b1, 16'h0001);
    send_beat(8'hAA, 1'b1, 1'b1, 16'h0002);
    send_beat(8'h00, 1'b0, 1'b0, 16'h0003);
    drain();

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin gap = 16'd0;    chk = 1'b0; end
        1: begin gap = 16'hFFFF; chk = 1'b1; end
        2: begin gap = cnt_t'($urandom_range(20, 60)); chk = 1'b1; end
        3: begin gap = 16'd0;    chk = 1'b1; end
        4: begin gap = cnt_t'($urandom_range(0, 65535)); chk = 1'b0; end
        default: begin
          gap = cnt_t'($urandom_range(10, 40));
          chk = bit'($urandom_range(0, 1));
        end
      endcase
      set_regs(gap, chk);
      phase_idle = (p < NUM_PHASES - 1);
      target     = (p + 1) * RUN_BEATS / NUM_PHASES;
      while (beats_in < target) begin
        send_idle = phase_idle && ($urandom_range(0, 3) != 0);
        recv_idle = phase_idle && ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 7) == 0)
          repeat ($urandom_range(1, 4))
            send_beat(byte_t'($urandom_range(0, 255)), bit'($urandom_range(0, 1)),
                      bit'($urandom_range(0, 1)), cnt_t'($urandom_range(0, 65535)));
        else
          send_frame();
      end
      recv_idle = 1'b0;
      drain();
    end

    $display("summary: %0d beats decoded, %0d errored beats dropped, %0d frames checked",
             beats_in, sb.dropped_beats, sb.frames_seen);
    $display("summary: gap from 0 to 65535, check mode on and off, %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.frames_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_cell.sv
hw/rtl/sbus_frame_receiver_decoder.sv
tb/sbus_frame_receiver_decoder_tb.sv
